// File: sv/cat_pkg.sv
// Shared codes and control structs for the compacting array table.
package cat_pkg;

  localparam int WORD_W = 32;

  // Action codes carried by in_action
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  // Status codes carried by out_status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Commands from the sequencer to the walk unit
  typedef struct packed {
    logic load;        // start a new walk from the given base
    logic shift_mode;  // walk moves entries down rather than searching
    logic run;         // walk is active this cycle
  } walk_ctl_t;

  // Status from the walk unit back to the sequencer
  typedef struct packed {
    logic rd_en;  // table read issued this cycle
    logic wr_en;  // shifted entry written this cycle
    logic match;  // pending read data equals the key
    logic done;   // walk ends this cycle
  } walk_sts_t;

endpackage

// File: sv/cat_ram.sv
// Generic simple dual-port RAM with registered read data.
module cat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/cat_walk.sv
// Walk unit: steps a read pointer over the table, compares or shifts down.
module cat_walk #(
  parameter int CAPACITY = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cat_pkg::walk_ctl_t            ctl,
  input  logic [$clog2(CAPACITY+1)-1:0] base,
  input  logic [$clog2(CAPACITY+1)-1:0] limit,
  input  logic [cat_pkg::WORD_W-1:0]    key,
  input  logic [cat_pkg::WORD_W-1:0]    rd_data,
  output cat_pkg::walk_sts_t            sts,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output logic [$clog2(CAPACITY)-1:0]   data_ptr
);

  import cat_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     data_ptr_r, data_ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              shift_r, shift_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic              can_read;
  logic              match;
  logic              rd_go;

  // Bound check shared by both walk kinds; the compare counts only when searching
  assign can_read = rd_ptr_r < limit;
  assign match    = pend_r && (rd_data == key_r) && !shift_r;
  assign rd_go    = ctl.run && can_read && !match;

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    data_ptr_nxt = data_ptr_r;
    pend_nxt     = pend_r;
    shift_nxt    = shift_r;
    key_nxt      = key_r;
    if (ctl.load) begin
      rd_ptr_nxt = base;
      pend_nxt   = 1'b0;
      shift_nxt  = ctl.shift_mode;
      key_nxt    = key;
    end else if (ctl.run) begin
      // advance the read pointer, remember where the pending data came from
      pend_nxt = rd_go;
      if (rd_go) begin
        rd_ptr_nxt   = CW'(rd_ptr_r + CW'(1));
        data_ptr_nxt = rd_ptr_r[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      shift_r <= shift_nxt;
    end
    rd_ptr_r   <= rd_ptr_nxt;
    data_ptr_r <= data_ptr_nxt;
    key_r      <= key_nxt;
  end

  // Report to the sequencer
  always_comb begin
    sts.rd_en = rd_go;
    sts.wr_en = ctl.run && shift_r && pend_r;
    sts.match = ctl.run && match;
    if (shift_r) begin
      sts.done = ctl.run && !can_read && !pend_r;
    end else begin
      sts.done = ctl.run && (match || !can_read);
    end
  end

  assign rd_addr  = rd_ptr_r[AW-1:0];
  assign wr_addr  = AW'(data_ptr_r - AW'(1));
  assign data_ptr = data_ptr_r;

endmodule

// File: sv/compacting_array_table_unit.sv
// Compacting array table: append, update, delete with shift-down, linear search.
// Append and update: the table is written when the item is accepted; the result then goes to the output register.
// Delete at slot s: every entry above s moves down by one slot; one entry moves per cycle.
// Search: one table read and compare per cycle, stopping at the first match or at the fill count.
// One item at a time over one table read port: a new item waits until the last result is loaded for output.
// Reset clears the fill count and control state; table contents stay undefined.
module compacting_array_table_unit #(
  parameter int CAPACITY = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [6:0]               in_slot,
  input  logic signed [31:0]       in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [6:0]               out_hit_slot,
  output logic [7:0]               out_fill_count
);

  import cat_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (CW > 7) ? CW : 7;
  localparam int HW = (AW > 7) ? AW : 7;
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int UW = (AW > 7) ? AW : 7;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [6:0]        res_hit_r, res_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [6:0]        out_hit_slot_r;
  logic [7:0]        out_fill_count_r;
  logic              out_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  walk_ctl_t         wctl;
  walk_sts_t         wsts;
  logic [AW-1:0]     w_rd_addr;
  logic [AW-1:0]     w_wr_addr;
  logic [AW-1:0]     w_data_ptr;
  logic [CW-1:0]     w_base;

  logic [SW-1:0]     slot_x;
  logic              slot_ok;
  logic [UW-1:0]     slot_u;
  logic [HW-1:0]     hit_x;
  logic [XW-1:0]     count_x;

  assign slot_x  = SW'(in_slot);
  assign slot_ok = slot_x < SW'(count_r);
  assign slot_u  = UW'(in_slot);
  assign hit_x   = HW'(w_data_ptr);
  assign count_x = XW'(count_r);
  assign w_base  = (in_action == ACT_DELETE) ? CW'(slot_x + SW'(1)) : '0;

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  cat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (wsts.rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (ram_rdata)
  );

  cat_walk #(
    .CAPACITY (CAPACITY)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wctl),
    .base     (w_base),
    .limit    (count_r),
    .key      (WORD_W'(in_word)),
    .rd_data  (ram_rdata),
    .sts      (wsts),
    .rd_addr  (w_rd_addr),
    .wr_addr  (w_wr_addr),
    .data_ptr (w_data_ptr)
  );

  // Sequence one item: decode, walk for delete and search, then hold the result for the output stage
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    res_status_nxt  = res_status_r;
    res_hit_nxt     = res_hit_r;
    ram_we          = 1'b0;
    ram_waddr       = w_wr_addr;
    ram_wdata       = ram_rdata;
    wctl.load       = 1'b0;
    wctl.shift_mode = (in_action == ACT_DELETE);
    wctl.run        = (state_r == S_SRCH) || (state_r == S_SHIFT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_hit_nxt = '0;
          state_nxt   = S_DONE;
          case (in_action)
            ACT_APPEND: begin
              if (count_r < CW'(CAPACITY)) begin
                ram_we         = 1'b1;
                ram_waddr      = count_r[AW-1:0];
                ram_wdata      = WORD_W'(in_word);
                count_nxt      = CW'(count_r + CW'(1));
                res_status_nxt = ST_OK;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            ACT_UPDATE: begin
              if (slot_ok) begin
                ram_we         = 1'b1;
                ram_waddr      = slot_u[AW-1:0];
                ram_wdata      = WORD_W'(in_word);
                res_status_nxt = ST_OK;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            ACT_DELETE: begin
              if (slot_ok) begin
                wctl.load = 1'b1;
                state_nxt = S_SHIFT;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            default: begin
              wctl.load = 1'b1;
              state_nxt = S_SRCH;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (wsts.done) begin
          res_status_nxt = wsts.match ? ST_OK : ST_NOT_FOUND;
          res_hit_nxt    = wsts.match ? hit_x[6:0] : '0;
          state_nxt      = S_DONE;
        end
      end
      S_SHIFT: begin
        // move the pending entry down by one
        ram_we = wsts.wr_en;
        if (wsts.done) begin
          count_nxt      = CW'(count_r - CW'(1));
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    if (out_load) begin
      out_status_r     <= res_status_r;
      out_hit_slot_r   <= res_hit_r;
      out_fill_count_r <= count_x[7:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit_slot   = out_hit_slot_r;
  assign out_fill_count = out_fill_count_r;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item left sequencer idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    wsts.wr_en |-> (state_r == S_SHIFT))
    else $error("shift write outside delete walk");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wsts.done) |=> (CW'(count_r + CW'(1)) == $past(count_r)))
    else $error("delete did not drop the fill count by one");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not reach output stage");
`endif

endmodule
